// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the transform matrix stack, used by the controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: hw/rtl/tms_pkg.sv
// Shared types, codes and constants of the transform matrix stack.
`default_nettype none

package tms_pkg;

  // Defaults for the top-level parameters.
  localparam int STACK_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // Fixed field widths.
  localparam int WORD_W    = 32;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;
  localparam int LVL_OUT_W = 5;
  localparam int MAT_WORDS = 9;
  localparam int IDX_W     = 4;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_IDENT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MULTIPLY   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TRANSFORM  = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Multiplier B operand codes beyond the nine operand matrix words.
  localparam logic [IDX_W-1:0] BSEL_VX  = 4'd9;
  localparam logic [IDX_W-1:0] BSEL_VY  = 4'd10;
  localparam logic [IDX_W-1:0] BSEL_ONE = 4'd11;

  typedef enum logic [1:0] {
    OSEL_ZERO,
    OSEL_VERTEX,
    OSEL_XFORM
  } tms_osel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SAVE,
    ST_RESTORE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } tms_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             capture;
    logic             mac_issue;
    logic             mac_first;
    logic             mac_last;
    logic [IDX_W-1:0] top_idx;
    logic [IDX_W-1:0] b_sel;
    logic [IDX_W-1:0] res_idx;
    logic             top_from_res;
    logic             top_ident;
    logic             mem_we;
    logic             mem_re;
    logic             out_load;
    tms_osel_t        out_sel;
  } tms_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/tms_datapath.sv
// Datapath: top matrix registers, stack memory, shared multiply-accumulate unit.
`default_nettype none

module tms_datapath #(
  parameter int STACK_DEPTH = tms_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = tms_pkg::FRAC_BITS_DEF,
  localparam int SLOTS  = STACK_DEPTH - 1,
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tms_pkg::tms_cmd_t                   cmd,
  input  logic [SLOT_W-1:0]                   mem_slot,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m00,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m01,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m02,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m10,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m11,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m12,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m20,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m21,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m22,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_vertex_x,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_vertex_y,
  output logic signed [tms_pkg::WORD_W-1:0]   out_x,
  output logic signed [tms_pkg::WORD_W-1:0]   out_y
);
  import tms_pkg::*;

  localparam int ACC_W     = FRAC_BITS + WORD_W;
  localparam int MEM_DEPTH = SLOTS * MAT_WORDS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam logic signed [WORD_W-1:0] FX_ONE = WORD_W'(64'sd1 << FRAC_BITS);

  logic signed [WORD_W-1:0]   op_r  [MAT_WORDS];
  logic signed [WORD_W-1:0]   top_r [MAT_WORDS];
  logic signed [WORD_W-1:0]   res_r [MAT_WORDS];
  logic signed [WORD_W-1:0]   mem   [MEM_DEPTH];
  logic signed [WORD_W-1:0]   vx_r, vy_r;
  logic signed [WORD_W-1:0]   rdata_r;
  logic                       rd_valid_r;
  logic [IDX_W-1:0]           rd_word_r;
  logic signed [WORD_W-1:0]   top_rd, b_op;
  logic signed [2*WORD_W-1:0] full_prod;
  logic [ACC_W-1:0]           prod_r, acc_r, acc_sum;
  logic                       p_valid_r, p_first_r, p_last_r;
  logic [IDX_W-1:0]           p_idx_r;
  logic [ADDR_W-1:0]          mem_addr;
  logic signed [WORD_W-1:0]   out_x_r, out_y_r;

  // Operands of the accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r[0] <= in_m00;
      op_r[1] <= in_m01;
      op_r[2] <= in_m02;
      op_r[3] <= in_m10;
      op_r[4] <= in_m11;
      op_r[5] <= in_m12;
      op_r[6] <= in_m20;
      op_r[7] <= in_m21;
      op_r[8] <= in_m22;
      vx_r    <= in_vertex_x;
      vy_r    <= in_vertex_y;
    end
  end

  // One top word feeds both the multiplier and memory writes.
  assign top_rd = top_r[cmd.top_idx];

  // B operand: an operand matrix word, a vertex coordinate, or fixed-point one
  // (which turns the translation column into a plain product).
  always_comb begin
    priority if (cmd.b_sel == BSEL_VX) begin
      b_op = vx_r;
    end else if (cmd.b_sel == BSEL_VY) begin
      b_op = vy_r;
    end else if (cmd.b_sel == BSEL_ONE) begin
      b_op = FX_ONE;
    end else begin
      b_op = op_r[cmd.b_sel];
    end
  end

  assign full_prod = top_rd * b_op;

  // Product stage; only the low ACC_W bits affect the reduced result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= cmd.mac_issue;
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= full_prod[ACC_W-1:0];
    p_first_r <= cmd.mac_first;
    p_last_r  <= cmd.mac_last;
    p_idx_r   <= cmd.res_idx;
  end

  // Accumulate stage, modulo 2^ACC_W.
  assign acc_sum = p_first_r ? prod_r : acc_r + prod_r;

  always_ff @(posedge clk) begin
    if (p_valid_r) begin
      acc_r <= acc_sum;
      if (p_last_r) begin
        res_r[p_idx_r] <= acc_sum[ACC_W-1:FRAC_BITS];
      end
    end
  end

  // Stack memory: slot s holds the matrix s levels from the bottom.
  assign mem_addr = ADDR_W'({mem_slot, 3'b000}) + ADDR_W'(mem_slot) + ADDR_W'(cmd.top_idx);

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[mem_addr] <= top_rd;
    end
    if (cmd.mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.mem_re;
    end
  end

  always_ff @(posedge clk) begin
    rd_word_r <= cmd.top_idx;
  end

  // Top matrix: identity after reset, then loaded as a whole or one word at a time.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.top_ident) begin
      for (int w = 0; w < MAT_WORDS; w++) begin
        top_r[w] <= (w == 0 || w == 4 || w == 8) ? FX_ONE : '0;
      end
    end else if (cmd.top_from_res) begin
      for (int w = 0; w < MAT_WORDS; w++) begin
        top_r[w] <= res_r[w];
      end
    end else if (rd_valid_r) begin
      top_r[rd_word_r] <= rdata_r;
    end
  end

  // Result coordinates.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        OSEL_VERTEX: begin
          out_x_r <= vx_r;
          out_y_r <= vy_r;
        end
        OSEL_XFORM: begin
          out_x_r <= res_r[0];
          out_y_r <= res_r[1];
        end
        default: begin
          out_x_r <= '0;
          out_y_r <= '0;
        end
      endcase
    end
  end

  assign out_x = out_x_r;
  assign out_y = out_y_r;

endmodule

`default_nettype wire

// File: hw/rtl/tms_ctrl.sv
// Controller: command decode, stack level, sequencing and the result handshake.
`default_nettype none

`include "assert_macros.svh"

module tms_ctrl #(
  parameter int STACK_DEPTH = tms_pkg::STACK_DEPTH_DEF,
  localparam int SLOTS  = STACK_DEPTH - 1,
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tms_pkg::CMD_W-1:0]       in_cmd,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tms_pkg::STAT_W-1:0]      out_status,
  output logic [tms_pkg::LVL_OUT_W-1:0]   out_stack_level,
  output tms_pkg::tms_cmd_t               dp_cmd,
  output logic [SLOT_W-1:0]               mem_slot
);
  import tms_pkg::*;

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(MAT_WORDS - 1);

  tms_state_t           state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [LVL_W-1:0]     level_r, level_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [STAT_W-1:0]    stat_r, stat_nxt;
  tms_osel_t            osel_r, osel_nxt;
  logic [1:0]           cnt_i_r, cnt_i_nxt, cnt_j_r, cnt_j_nxt, cnt_k_r, cnt_k_nxt;
  logic [IDX_W-1:0]     word_r, word_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    out_status_r, out_status_nxt;
  logic [LVL_OUT_W-1:0] out_level_r, out_level_nxt;
  logic                 is_empty, is_full, is_mul;

  assign is_empty = (level_r == '0);
  assign is_full  = (level_r >= LVL_W'(STACK_DEPTH));
  assign is_mul   = (cmd_r == CMD_MULTIPLY);

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      level_r     <= LVL_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    slot_r       <= slot_nxt;
    stat_r       <= stat_nxt;
    osel_r       <= osel_nxt;
    cnt_i_r      <= cnt_i_nxt;
    cnt_j_r      <= cnt_j_nxt;
    cnt_k_r      <= cnt_k_nxt;
    word_r       <= word_nxt;
    out_status_r <= out_status_nxt;
    out_level_r  <= out_level_nxt;
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    level_nxt      = level_r;
    slot_nxt       = slot_r;
    stat_nxt       = stat_r;
    osel_nxt       = osel_r;
    cnt_i_nxt      = cnt_i_r;
    cnt_j_nxt      = cnt_j_r;
    cnt_k_nxt      = cnt_k_r;
    word_nxt       = word_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_level_nxt  = out_level_r;
    dp_cmd         = '0;
    dp_cmd.out_sel = osel_r;
    dp_cmd.top_idx = word_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          dp_cmd.capture = 1'b1;
          cmd_nxt        = in_cmd;
          state_nxt      = ST_DECODE;
        end
      end

      ST_DECODE: begin
        stat_nxt  = STAT_OK;
        osel_nxt  = OSEL_ZERO;
        word_nxt  = '0;
        cnt_i_nxt = '0;
        cnt_j_nxt = '0;
        cnt_k_nxt = '0;
        state_nxt = ST_FINISH;
        unique case (cmd_r)
          CMD_PUSH: begin
            if (is_empty) begin
              stat_nxt = STAT_EMPTY;
            end else if (is_full) begin
              stat_nxt = STAT_FULL;
            end else begin
              slot_nxt  = SLOT_W'(level_r - LVL_W'(1));
              level_nxt = level_r + LVL_W'(1);
              state_nxt = ST_SAVE;
            end
          end
          CMD_POP: begin
            if (is_empty) begin
              stat_nxt = STAT_EMPTY;
            end else begin
              level_nxt = level_r - LVL_W'(1);
              if (level_r >= LVL_W'(2)) begin
                slot_nxt  = SLOT_W'(level_r - LVL_W'(2));
                state_nxt = ST_RESTORE;
              end
            end
          end
          CMD_LOAD_IDENT: begin
            if (is_full) begin
              stat_nxt = STAT_FULL;
            end else begin
              level_nxt = level_r + LVL_W'(1);
              if (is_empty) begin
                // Nothing below to save: the new identity becomes the only matrix.
                dp_cmd.top_ident = 1'b1;
              end else begin
                slot_nxt  = SLOT_W'(level_r - LVL_W'(1));
                state_nxt = ST_SAVE;
              end
            end
          end
          CMD_MULTIPLY: begin
            if (is_empty) begin
              stat_nxt = STAT_EMPTY;
            end else begin
              state_nxt = ST_MAC;
            end
          end
          CMD_TRANSFORM: begin
            if (is_empty) begin
              stat_nxt = STAT_EMPTY;
              osel_nxt = OSEL_VERTEX;
            end else begin
              osel_nxt  = OSEL_XFORM;
              state_nxt = ST_MAC;
            end
          end
          default: begin
            // Unknown codes leave the stack alone and report zeros.
          end
        endcase
      end

      // Copy the current top into its memory slot, one word a cycle.
      ST_SAVE: begin
        dp_cmd.mem_we = 1'b1;
        if (word_r == LAST_WORD) begin
          dp_cmd.top_ident = (cmd_r == CMD_LOAD_IDENT);
          state_nxt        = ST_FINISH;
        end else begin
          word_nxt = word_r + IDX_W'(1);
        end
      end

      // Bring the matrix below back into the top registers.
      ST_RESTORE: begin
        dp_cmd.mem_re = 1'b1;
        if (word_r == LAST_WORD) begin
          state_nxt = ST_DRAIN;
        end else begin
          word_nxt = word_r + IDX_W'(1);
        end
      end

      // One product per cycle: row i of the top times column j of the operand,
      // or row i of the top times (x, y, 1) for a vertex.
      ST_MAC: begin
        dp_cmd.mac_issue = 1'b1;
        dp_cmd.mac_first = (cnt_k_r == 2'd0);
        dp_cmd.mac_last  = (cnt_k_r == 2'd2);
        dp_cmd.top_idx   = IDX_W'({cnt_i_r, 1'b0}) + IDX_W'(cnt_i_r) + IDX_W'(cnt_k_r);
        if (is_mul) begin
          dp_cmd.b_sel   = IDX_W'({cnt_k_r, 1'b0}) + IDX_W'(cnt_k_r) + IDX_W'(cnt_j_r);
          dp_cmd.res_idx = IDX_W'({cnt_i_r, 1'b0}) + IDX_W'(cnt_i_r) + IDX_W'(cnt_j_r);
        end else begin
          dp_cmd.b_sel   = (cnt_k_r == 2'd0) ? BSEL_VX :
                           (cnt_k_r == 2'd1) ? BSEL_VY : BSEL_ONE;
          dp_cmd.res_idx = IDX_W'(cnt_i_r);
        end
        if (cnt_k_r != 2'd2) begin
          cnt_k_nxt = cnt_k_r + 2'd1;
        end else begin
          cnt_k_nxt = 2'd0;
          if (is_mul && cnt_j_r != 2'd2) begin
            cnt_j_nxt = cnt_j_r + 2'd1;
          end else begin
            cnt_j_nxt = 2'd0;
            if ((is_mul && cnt_i_r == 2'd2) || (!is_mul && cnt_i_r == 2'd1)) begin
              state_nxt = ST_DRAIN;
            end else begin
              cnt_i_nxt = cnt_i_r + 2'd1;
            end
          end
        end
      end

      // Last accumulate or last restored word lands.
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end

      // Hand the result to the output register once it is free.
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          dp_cmd.out_load     = 1'b1;
          dp_cmd.top_from_res = is_mul && (stat_r == STAT_OK);
          out_valid_nxt       = 1'b1;
          out_status_nxt      = stat_r;
          out_level_nxt       = LVL_OUT_W'(level_r);
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_stack_level = out_level_r;
  assign mem_slot        = slot_r;

  // Checks on level bookkeeping and sequencing.
  `ASSERT_NEVER(a_level_bound, clk, rst_n, level_r > LVL_W'(STACK_DEPTH), "stack level above depth")
  `ASSERT_CLKD(a_accept_decode, clk, rst_n, in_valid && !in_stall |=> state_r == ST_DECODE, "accepted beat not decoded")
  `ASSERT_CLKD(a_out_from_finish, clk, rst_n, $rose(out_valid_r) |-> $past(state_r) == ST_FINISH, "result raised outside finish")
  `ASSERT_CLKD(a_save_slot, clk, rst_n, state_r == ST_SAVE |-> slot_r == SLOT_W'(level_r - LVL_W'(2)), "save slot does not match level")
  `ASSERT_CLKD(a_restore_slot, clk, rst_n, state_r == ST_RESTORE |-> slot_r == SLOT_W'(level_r - LVL_W'(1)), "restore slot does not match level")

endmodule

`default_nettype wire

// File: hw/rtl/transform_matrix_stack_unit.sv
// Top level of the transform matrix stack: controller and datapath.
`default_nettype none

// Stack of 3x3 signed fixed-point transform matrices (FRAC_BITS fraction bits), with
// the top matrix held in registers and the matrices below it in a single-port memory
// of (STACK_DEPTH-1)*9 words; reset leaves one identity matrix, no clearing pass is
// needed. Every input beat gives exactly one result beat, and no new beat is taken
// until the last one has reached the output register. One 32x32 multiplier is shared
// over all products (27 for a multiply, 6 for a transform), and one memory word is
// moved per cycle when a push or load identity saves the top or a pop restores the
// matrix below. A finished result waits in the output register while the next beat
// is taken.
module transform_matrix_stack_unit #(
  parameter int STACK_DEPTH = tms_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = tms_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tms_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m00,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m01,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m02,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m10,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m11,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m12,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m20,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m21,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_m22,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_vertex_x,
  input  logic signed [tms_pkg::WORD_W-1:0]   in_vertex_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tms_pkg::WORD_W-1:0]   out_x,
  output logic signed [tms_pkg::WORD_W-1:0]   out_y,
  output logic [tms_pkg::STAT_W-1:0]          out_status,
  output logic [tms_pkg::LVL_OUT_W-1:0]       out_stack_level
);
  import tms_pkg::*;

  localparam int SLOTS  = STACK_DEPTH - 1;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  tms_cmd_t          dp_cmd;
  logic [SLOT_W-1:0] mem_slot;

  // Sequencing and stack bookkeeping.
  tms_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_stack_level (out_stack_level),
    .dp_cmd          (dp_cmd),
    .mem_slot        (mem_slot)
  );

  // Matrix storage and arithmetic.
  tms_datapath #(
    .STACK_DEPTH(STACK_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (dp_cmd),
    .mem_slot    (mem_slot),
    .in_m00      (in_m00),
    .in_m01      (in_m01),
    .in_m02      (in_m02),
    .in_m10      (in_m10),
    .in_m11      (in_m11),
    .in_m12      (in_m12),
    .in_m20      (in_m20),
    .in_m21      (in_m21),
    .in_m22      (in_m22),
    .in_vertex_x (in_vertex_x),
    .in_vertex_y (in_vertex_y),
    .out_x       (out_x),
    .out_y       (out_y)
  );

endmodule

`default_nettype wire

// File: verif/tb_transform_matrix_stack_unit.sv
// Self-checking testbench for the transform matrix stack: directed, pressure and random traffic.
`timescale 1ns / 100ps

module tb_transform_matrix_stack_unit;
  import tms_pkg::*;

  localparam int DEPTH            = STACK_DEPTH_DEF;
  localparam int FRAC             = FRAC_BITS_DEF;
  localparam int RESET_CYCLES     = 7;
  localparam int RANDOM_ITEMS     = 980;
  localparam int PRESSURE_ITEMS   = 40;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 40;
  localparam int WATCHDOG_LIMIT   = 2000;

  // Command codes that the block treats as no operation.
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

  localparam logic [WORD_W-1:0] FX_ONE       = 32'h0000_0001 << FRAC;
  localparam logic [WORD_W-1:0] FX_NEG_ONE   = -(32'h0000_0001 << FRAC);
  localparam logic [WORD_W-1:0] WORD_MIN     = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX     = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_NEG_ONE = 32'hFFFF_FFFF;

  // Row-major matrix; element 0 is row 0 column 0.
  typedef logic [MAT_WORDS-1:0][WORD_W-1:0] mat3_t;

  localparam mat3_t IDENT_MAT = {FX_ONE, 32'd0, 32'd0, 32'd0, FX_ONE, 32'd0, 32'd0, 32'd0, FX_ONE};

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    mat3_t             mat;
    logic [WORD_W-1:0] vx;
    logic [WORD_W-1:0] vy;
  } stack_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0]    x;
    logic [WORD_W-1:0]    y;
    logic [STAT_W-1:0]    status;
    logic [LVL_OUT_W-1:0] level;
  } vertex_result_t;

  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_STEADY
  } cmd_mix_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_cmd = CMD_PUSH;
  logic [WORD_W-1:0]    in_m00 = '0, in_m01 = '0, in_m02 = '0;
  logic [WORD_W-1:0]    in_m10 = '0, in_m11 = '0, in_m12 = '0;
  logic [WORD_W-1:0]    in_m20 = '0, in_m21 = '0, in_m22 = '0;
  logic [WORD_W-1:0]    in_vertex_x = '0, in_vertex_y = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WORD_W-1:0]    out_x, out_y;
  logic [STAT_W-1:0]    out_status;
  logic [LVL_OUT_W-1:0] out_stack_level;

  // Mirror of the block's stack, kept in step with accepted beats.
  mat3_t          stack_mem [DEPTH];
  int             stack_count;
  vertex_result_t expected_q [$];

  int err_count   = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  bit hold_req    = 1'b0;
  int hold_left   = 0;
  int stall_pct   = 0;
  int stall_phase = 0;
  int idle_cycles = 0;

  transform_matrix_stack_unit #(
    .STACK_DEPTH(DEPTH),
    .FRAC_BITS(FRAC)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_m00(in_m00),
    .in_m01(in_m01),
    .in_m02(in_m02),
    .in_m10(in_m10),
    .in_m11(in_m11),
    .in_m12(in_m12),
    .in_m20(in_m20),
    .in_m21(in_m21),
    .in_m22(in_m22),
    .in_vertex_x(in_vertex_x),
    .in_vertex_y(in_vertex_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_x(out_x),
    .out_y(out_y),
    .out_status(out_status),
    .out_stack_level(out_stack_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Three-term fixed-point dot product: full 64-bit products, wrapping sum,
  // arithmetic shift by the fraction width, low 32 bits kept.
  function automatic logic [WORD_W-1:0] fixed_dot(input logic [WORD_W-1:0] a0, b0, a1, b1,
                                                  a2, b2);
    logic signed [63:0] acc;
    acc = longint'(signed'(a0)) * longint'(signed'(b0))
        + longint'(signed'(a1)) * longint'(signed'(b1))
        + longint'(signed'(a2)) * longint'(signed'(b2));
    return acc[FRAC +: WORD_W];
  endfunction

  // Applies one beat to the mirrored stack and returns the result it should give.
  function automatic vertex_result_t apply_stack_cmd(input stack_beat_t b);
    vertex_result_t r;
    mat3_t          top;
    mat3_t          prod;
    r = '0;
    r.status = STAT_OK;
    case (b.cmd)
      CMD_PUSH: begin
        if (stack_count == 0) begin
          r.status = STAT_EMPTY;
        end else if (stack_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          stack_mem[stack_count] = stack_mem[stack_count-1];
          stack_count++;
        end
      end
      CMD_POP: begin
        if (stack_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          stack_count--;
        end
      end
      CMD_LOAD_IDENT: begin
        if (stack_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          stack_mem[stack_count] = IDENT_MAT;
          stack_count++;
        end
      end
      CMD_MULTIPLY: begin
        if (stack_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          top = stack_mem[stack_count-1];
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              prod[i*3+j] = fixed_dot(top[i*3], b.mat[j], top[i*3+1], b.mat[3+j],
                                      top[i*3+2], b.mat[6+j]);
            end
          end
          stack_mem[stack_count-1] = prod;
        end
      end
      CMD_TRANSFORM: begin
        if (stack_count == 0) begin
          r.status = STAT_EMPTY;
          r.x = b.vx;
          r.y = b.vy;
        end else begin
          // The translation column is weighted by one in fixed point.
          top = stack_mem[stack_count-1];
          r.x = fixed_dot(top[0], b.vx, top[1], b.vy, top[2], FX_ONE);
          r.y = fixed_dot(top[3], b.vx, top[4], b.vy, top[5], FX_ONE);
        end
      end
      default: begin
      end
    endcase
    r.level = LVL_OUT_W'(stack_count);
    return r;
  endfunction

  // Checks each result beat against the oldest expectation, then records the
  // expectation for a beat accepted at this edge.
  always @(posedge clk) begin : scoreboard
    vertex_result_t exp_r;
    stack_beat_t    cur;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          err_count++;
          $error("result beat with no expected result");
        end else begin
          exp_r = expected_q.pop_front();
          if (out_x !== exp_r.x) begin
            err_count++;
            $error("out_x: expected %0d, got %0d", signed'(exp_r.x), signed'(out_x));
          end
          if (out_y !== exp_r.y) begin
            err_count++;
            $error("out_y: expected %0d, got %0d", signed'(exp_r.y), signed'(out_y));
          end
          if (out_status !== exp_r.status) begin
            err_count++;
            $error("out_status: expected %0d, got %0d", exp_r.status, out_status);
          end
          if (out_stack_level !== exp_r.level) begin
            err_count++;
            $error("out_stack_level: expected %0d, got %0d", exp_r.level, out_stack_level);
          end
        end
      end
      if (in_valid && !in_stall) begin
        cur.cmd = in_cmd;
        cur.mat = {in_m22, in_m21, in_m20, in_m12, in_m11, in_m10, in_m02, in_m01, in_m00};
        cur.vx  = in_vertex_x;
        cur.vy  = in_vertex_y;
        expected_q.push_back(apply_stack_cmd(cur));
      end
    end
  end

  // Receiver: stall density changes from phase to phase; a requested long
  // hold overrides it so the block backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req || hold_left > 0) begin
      if (hold_req) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_phase == 0) begin
        stall_phase = $urandom_range(10, 150);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      stall_phase--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL transform_matrix_stack_unit");
        $finish;
      end
    end
  end

  function automatic logic [WORD_W-1:0] rand_coord();
    if ($urandom_range(0, 1) == 0) begin
      return 32'(int'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000);
    end
    return $urandom;
  endfunction

  // Operand matrices: fully random words, affine-shaped matrices near unit
  // scale, or a mix of corner values.
  function automatic mat3_t rand_matrix();
    mat3_t m;
    int    kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < MAT_WORDS; k++) begin
      if (kind < 3) begin
        m[k] = $urandom;
      end else if (kind < 8) begin
        if (k >= 6) begin
          m[k] = (k == 8) ? FX_ONE : 32'd0;
        end else if (k % 3 == 2) begin
          m[k] = 32'(int'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000);
        end else begin
          m[k] = 32'(int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000);
        end
      end else begin
        case ($urandom_range(0, 5))
          0:       m[k] = 32'd0;
          1:       m[k] = FX_ONE;
          2:       m[k] = WORD_MIN;
          3:       m[k] = WORD_MAX;
          4:       m[k] = WORD_NEG_ONE;
          default: m[k] = $urandom;
        endcase
      end
    end
    return m;
  endfunction

  function automatic stack_beat_t rand_beat(input logic [CMD_W-1:0] cmd);
    stack_beat_t b;
    b.cmd = cmd;
    b.mat = rand_matrix();
    b.vx  = rand_coord();
    b.vy  = rand_coord();
    return b;
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input cmd_mix_t mix);
    int r;
    int p_push, p_load, p_pop, p_mul;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:   begin p_push = 25; p_load = 20; p_pop = 10; p_mul = 20; end
      MIX_SHRINK: begin p_push = 8;  p_load = 7;  p_pop = 35; p_mul = 20; end
      default:    begin p_push = 15; p_load = 10; p_pop = 15; p_mul = 25; end
    endcase
    if (r < 3) return CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
    r -= 3;
    if (r < p_push) return CMD_PUSH;
    r -= p_push;
    if (r < p_load) return CMD_LOAD_IDENT;
    r -= p_load;
    if (r < p_pop) return CMD_POP;
    r -= p_pop;
    if (r < p_mul) return CMD_MULTIPLY;
    return CMD_TRANSFORM;
  endfunction

  task automatic drive_payload(input stack_beat_t b);
    in_cmd      <= b.cmd;
    in_m00      <= b.mat[0];
    in_m01      <= b.mat[1];
    in_m02      <= b.mat[2];
    in_m10      <= b.mat[3];
    in_m11      <= b.mat[4];
    in_m12      <= b.mat[5];
    in_m20      <= b.mat[6];
    in_m21      <= b.mat[7];
    in_m22      <= b.mat[8];
    in_vertex_x <= b.vx;
    in_vertex_y <= b.vy;
  endtask

  // Offers one beat and returns at the edge where it is taken. Beats go out in
  // bursts; between bursts valid may drop for a while over junk payload.
  task automatic send_beat(input stack_beat_t b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        drive_payload(rand_beat(CMD_W'($urandom)));
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    drive_payload(b);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Corner values through the arithmetic and the unused command codes.
  task automatic test_directed_arith();
    stack_beat_t b;
    b = rand_beat(CMD_TRANSFORM);
    b.vx = WORD_MAX;
    b.vy = WORD_MIN;
    send_beat(b);
    b = rand_beat(CMD_MULTIPLY);
    // Listed from row 2 column 2 down to row 0 column 0.
    b.mat = {WORD_MIN, WORD_MAX, WORD_NEG_ONE, 32'd0, 32'd1, FX_ONE, WORD_MAX, WORD_MIN,
             FX_NEG_ONE};
    send_beat(b);
    b = rand_beat(CMD_TRANSFORM);
    b.vx = WORD_MIN;
    b.vy = WORD_NEG_ONE;
    send_beat(b);
    for (int c = int'(CMD_RSVD_FIRST); c <= int'(CMD_RSVD_LAST); c++) begin
      send_beat(rand_beat(CMD_W'(c)));
    end
  endtask

  // Drains the stack and works every command on it while it is empty.
  task automatic test_directed_empty();
    stack_beat_t b;
    send_beat(rand_beat(CMD_POP));
    send_beat(rand_beat(CMD_POP));
    send_beat(rand_beat(CMD_PUSH));
    send_beat(rand_beat(CMD_MULTIPLY));
    b = rand_beat(CMD_TRANSFORM);
    b.vx = WORD_MIN;
    b.vy = WORD_MAX;
    send_beat(b);
    send_beat(rand_beat(CMD_LOAD_IDENT));
    send_beat(rand_beat(CMD_TRANSFORM));
  endtask

  // Fills the stack, then pushes and loads onto the full stack.
  task automatic test_directed_full();
    for (int i = 1; i < DEPTH; i++) begin
      send_beat(rand_beat((i % 2 == 0) ? CMD_LOAD_IDENT : CMD_PUSH));
    end
    send_beat(rand_beat(CMD_PUSH));
    send_beat(rand_beat(CMD_LOAD_IDENT));
  endtask

  // Receiver holds off for a long stretch while beats are offered back to back.
  task automatic test_output_backpressure();
    gaps_on    = 1'b0;
    burst_left = 0;
    hold_req   = 1'b1;
    repeat (PRESSURE_ITEMS) send_beat(rand_beat(pick_cmd(MIX_STEADY)));
    gaps_on = 1'b1;
  endtask

  // Nested push / multiply / transform / pop blocks as a renderer would issue
  // them, with runs of loosely weighted commands that drive the stack toward
  // its full and empty ends.
  task automatic test_random_traffic(input int n_items);
    int       start;
    int       nest;
    cmd_mix_t mix;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 9) < 6) begin
        nest = $urandom_range(1, 6);
        for (int i = 0; i < nest; i++) begin
          send_beat(rand_beat(($urandom_range(0, 3) == 0) ? CMD_LOAD_IDENT : CMD_PUSH));
          repeat ($urandom_range(1, 2)) send_beat(rand_beat(CMD_MULTIPLY));
          repeat ($urandom_range(0, 3)) send_beat(rand_beat(CMD_TRANSFORM));
        end
        repeat ($urandom_range(1, 6)) send_beat(rand_beat(CMD_TRANSFORM));
        repeat (nest) send_beat(rand_beat(CMD_POP));
      end else begin
        mix = cmd_mix_t'($urandom_range(0, 2));
        repeat ($urandom_range(5, 20)) send_beat(rand_beat(pick_cmd(mix)));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      stack_mem[i] = '0;
    end
    stack_mem[0] = IDENT_MAT;
    stack_count  = 1;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_arith();
    test_directed_empty();
    test_directed_full();
    test_output_backpressure();
    test_random_traffic(RANDOM_ITEMS);
    in_valid <= 1'b0;

    // Let every result come back, then watch for stray beats.
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("PASS transform_matrix_stack_unit");
    end else begin
      $display("FAIL transform_matrix_stack_unit");
    end
    $finish;
  end

endmodule
